### sv/tes_pkg.sv
// Shared types and byte constants for the terminal escape stripper.
package tes_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_CSI     = 3'd2,
    MODE_STR     = 3'd3,
    MODE_STR_ESC = 3'd4
  } mode_t;

  localparam logic [7:0] BYTE_BEL   = 8'h07;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_NL    = 8'h0A;
  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_SP    = 8'h20;
  localparam logic [7:0] BYTE_DEL   = 8'h7F;
  localparam logic [7:0] CSI_LO     = 8'h40;
  localparam logic [7:0] CSI_HI     = 8'h7E;
  localparam logic [7:0] BYTE_CSI   = 8'h5B;
  localparam logic [7:0] BYTE_OSC   = 8'h5D;
  localparam logic [7:0] BYTE_APC   = 8'h5F;
  localparam logic [7:0] BYTE_DCS   = 8'h50;
  localparam logic [7:0] BYTE_BSL   = 8'h5C;

  typedef struct packed {
    mode_t mode_next;
    logic  keep;
  } step_res_t;

endpackage

### sv/tes_stream_if.sv
// Valid/ready stream interfaces for raw text bytes and filtered results.
interface tes_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface tes_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       kept;
  logic       text_done;

  modport source (output valid, output out_byte, output kept, output text_done, input ready);
  modport sink (input valid, input out_byte, input kept, input text_done, output ready);
endinterface

### sv/tes_step.sv
// Parser step: next mode and keep decision for one byte in the current mode.
module tes_step (
  input  logic [7:0]        data,
  input  tes_pkg::mode_t    mode,
  output tes_pkg::step_res_t res
);
  import tes_pkg::*;

  mode_t nrm_next;
  logic  nrm_keep;
  mode_t str_next;

  // Handling of a byte outside any sequence.
  always_comb begin
    nrm_next = MODE_NORMAL;
    nrm_keep = 1'b0;
    if (data == BYTE_ESC) begin
      nrm_next = MODE_ESC;
    end else if (data < BYTE_SP && data != BYTE_TAB && data != BYTE_NL) begin
      nrm_keep = 1'b0;
    end else if (data == BYTE_DEL) begin
      nrm_keep = 1'b0;
    end else begin
      nrm_keep = 1'b1;
    end
  end

  // Handling of a byte inside a string sequence.
  always_comb begin
    if (data == BYTE_BEL) begin
      str_next = MODE_NORMAL;
    end else if (data == BYTE_ESC) begin
      str_next = MODE_STR_ESC;
    end else begin
      str_next = MODE_STR;
    end
  end

  always_comb begin
    res.mode_next = MODE_NORMAL;
    res.keep      = 1'b0;
    unique case (mode)
      MODE_ESC: begin
        if (data == BYTE_CSI) begin
          res.mode_next = MODE_CSI;
        end else if (data == BYTE_OSC || data == BYTE_APC || data == BYTE_DCS) begin
          res.mode_next = MODE_STR;
        end else begin
          res.mode_next = nrm_next;
          res.keep      = nrm_keep;
        end
      end
      MODE_CSI: begin
        res.mode_next = (data >= CSI_LO && data <= CSI_HI) ? MODE_NORMAL : MODE_CSI;
      end
      MODE_STR: begin
        res.mode_next = str_next;
      end
      MODE_STR_ESC: begin
        res.mode_next = (data == BYTE_BSL) ? MODE_NORMAL : str_next;
      end
      default: begin
        res.mode_next = nrm_next;
        res.keep      = nrm_keep;
      end
    endcase
  end

endmodule

### sv/terminal_escape_stripper_unit.sv
// Top level: input register, parser mode register and result register.
// An accepted item moves from the input register into the result register; while a result
// waits, the input register can take one item. One item per cycle while results are taken.
// The mode register advances only as an item moves from input to result register.
// Reset (rst, synchronous) empties both registers and returns the parser to normal mode.
module terminal_escape_stripper_unit (
  input logic         clk,
  input logic         rst,
  tes_in_if.sink      text_in,
  tes_out_if.source   text_out
);
  import tes_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eot;
  mode_t      mode;
  mode_t      mode_next;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_kept;
  logic       out_done;
  logic       advance;
  step_res_t  step;

  assign advance       = s1_valid && (!out_valid || text_out.ready);
  assign text_in.ready = !s1_valid || advance;

  tes_step u_step (
    .data (s1_byte),
    .mode (mode),
    .res  (step)
  );

  // A text's last byte always sends the parser back to normal mode.
  assign mode_next = s1_eot ? MODE_NORMAL : step.mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text_in.ready) begin
      s1_valid <= text_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_in.valid && text_in.ready) begin
      s1_byte <= text_in.in_byte;
      s1_eot  <= text_in.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
    end else if (advance) begin
      mode <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (text_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= step.keep ? s1_byte : 8'h00;
      out_kept <= step.keep;
      out_done <= s1_eot;
    end
  end

  assign text_out.valid     = out_valid;
  assign text_out.out_byte  = out_byte;
  assign text_out.kept      = out_kept;
  assign text_out.text_done = out_done;

  a_eot_resets_mode: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_eot) |=> mode == MODE_NORMAL)
    else $error("parser mode not normal after end of text");

  a_seq_dropped: assert property (@(posedge clk) disable iff (rst)
    (advance && (mode == MODE_CSI || mode == MODE_STR || mode == MODE_STR_ESC))
    |=> !out_kept)
    else $error("byte inside a sequence was kept");

  a_kept_printable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kept) |->
    ((out_byte >= BYTE_SP && out_byte != BYTE_DEL) ||
     out_byte == BYTE_TAB || out_byte == BYTE_NL))
    else $error("control byte kept");

  a_dropped_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_kept) |-> out_byte == 8'h00)
    else $error("dropped item carries a non-zero byte");

endmodule
